### design/keyed_flag_registry_top_defines.svh
// assertion macros used by the registry top module
`ifndef KEYED_FLAG_REGISTRY_TOP_DEFINES_SVH
`define KEYED_FLAG_REGISTRY_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define KFR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("keyed flag registry check failed");
// next-cycle implication, checked out of reset
`define KFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("keyed flag registry check failed");
`else
`define KFR_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define KFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### design/kfr_pkg.sv
`timescale 1ns / 1ps

package kfr_pkg;

    // default table capacity
    localparam int CAPACITY_DEF = 64;

    // field widths fixed by the interface
    localparam int HASH_W     = 15;
    localparam int SLOT_SEL_W = 7;
    localparam int SLOT_OUT_W = 6;

    // only the low hash bits form the key
    localparam logic [15:0] HASH_MASK = 16'h7fff;

    // result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_HIT  = 2'd0;
    localparam t_status ST_NEW  = 2'd1;
    localparam t_status ST_FULL = 2'd2;
    localparam t_status ST_BAD  = 2'd3;

    // action codes
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    // input transaction
    typedef struct packed {
        logic                  action;
        logic [15:0]           key_hash;
        logic [15:0]           key_zone;
        logic [15:0]           key_link;
        logic [SLOT_SEL_W-1:0] slot_select;
        logic                  new_value;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot_index;
        logic                  stored_value;
        t_status               status;
    } t_out_item;

    // stored key of one entry
    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [15:0]       zone;
        logic [15:0]       link;
    } t_key;

    // search packet moving down the chain
    typedef struct packed {
        logic valid;
        logic found;
        logic flag;
        t_key key;
    } t_pkt;

    // broadcast write bus into the cells
    typedef struct packed {
        logic key_en;
        logic flag_en;
        logic flag;
        t_key key;
    } t_wr;

endpackage

### design/kfr_cell.sv
`timescale 1ns / 1ps

module kfr_cell
    import kfr_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX      = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(CAPACITY+1)-1:0] i_count,
    input  t_wr                           i_wr,
    input  logic [$clog2(CAPACITY)-1:0]   i_wr_slot,
    input  t_pkt                          i_pkt,
    input  logic [$clog2(CAPACITY)-1:0]   i_slot,
    output t_pkt                          o_pkt,
    output logic [$clog2(CAPACITY)-1:0]   o_slot
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_key          r_key;
    logic          r_flag;
    t_pkt          r_pkt;
    t_pkt          n_pkt;
    logic [IW-1:0] r_slot;
    logic [IW-1:0] n_slot;
    logic          w_live;
    logic          w_sel;
    logic          w_hit;

    // entry is allocated and addressed by the write bus
    assign w_live = (CW'(IDX) < i_count);
    assign w_sel  = (i_wr_slot == IW'(IDX));

    // first allocated match along the chain wins
    assign w_hit = i_pkt.valid && !i_pkt.found && w_live && (r_key == i_pkt.key);

    always_comb begin
        n_pkt  = i_pkt;
        n_slot = i_slot;
        if (w_hit) begin
            n_pkt.found = 1'b1;
            n_pkt.flag  = r_flag;
            n_slot      = IW'(IDX);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_sel && i_wr.key_en) begin
            r_key <= i_wr.key;
        end
        if (w_sel && (i_wr.key_en || i_wr.flag_en)) begin
            r_flag <= i_wr.flag;
        end
    end

    // packet stage toward the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt.valid <= 1'b0;
        end else begin
            r_pkt.valid <= n_pkt.valid;
        end
        r_pkt.found <= n_pkt.found;
        r_pkt.flag  <= n_pkt.flag;
        r_pkt.key   <= n_pkt.key;
        r_slot      <= n_slot;
    end

    assign o_pkt  = r_pkt;
    assign o_slot = r_slot;

endmodule

### design/keyed_flag_registry_top.sv
// lookup: the search packet walks the cell chain one cell per cycle, then the result
// strobe is registered; busy blocks new transactions until the lookup completes
// update: result strobe in the cycle after accept, one update per cycle while not busy
// results are strobed for one cycle; the receiver cannot stall
// synchronous active-low reset empties the table and clears control; entries keep data
`timescale 1ns / 1ps
`include "keyed_flag_registry_top_defines.svh"

module keyed_flag_registry_top
    import kfr_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_in,
    output logic      o_done,
    output t_out_item o_result
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = (CW > SLOT_SEL_W) ? CW : SLOT_SEL_W;
    localparam int XW = (IW > SLOT_OUT_W) ? IW : SLOT_OUT_W;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic          r_busy;
    logic          n_busy;
    logic          r_done;
    logic          n_done;
    t_out_item     r_result;
    t_out_item     n_result;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    t_wr           w_wr;
    logic [IW-1:0] w_wr_slot;
    t_key          w_key_in;
    t_pkt          w_pkt [0:CAPACITY];
    logic [IW-1:0] w_slot [0:CAPACITY];
    logic [SW-1:0] w_sel_x;
    logic [SW-1:0] w_cnt_x;
    logic [XW-1:0] w_hit_x;
    logic [XW-1:0] w_new_x;
    logic          w_lookup_acc;
    logic          w_new_done;

    // key as stored: masked hash, zone, link
    assign w_key_in.hash = HASH_W'(i_in.key_hash & HASH_MASK);
    assign w_key_in.zone = i_in.key_zone;
    assign w_key_in.link = i_in.key_link;

    // widened views for compares and the narrow slot report
    assign w_sel_x = SW'(i_in.slot_select);
    assign w_cnt_x = SW'(r_count);
    assign w_hit_x = XW'(w_slot[CAPACITY]);
    assign w_new_x = XW'(r_count[IW-1:0]);

    // search chain, one entry per cell
    assign w_slot[0] = '0;
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        kfr_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_count   (r_count),
            .i_wr      (w_wr),
            .i_wr_slot (w_wr_slot),
            .i_pkt     (w_pkt[g]),
            .i_slot    (w_slot[g]),
            .o_pkt     (w_pkt[g+1]),
            .o_slot    (w_slot[g+1])
        );
    end

    // control: accept, inject, finish
    always_comb begin
        n_state     = r_state;
        n_busy      = r_busy;
        n_done      = 1'b0;
        n_result    = r_result;
        n_count     = r_count;
        w_wr        = '0;
        w_wr.key    = w_key_in;
        w_wr_slot   = '0;
        w_pkt[0]    = '0;
        w_pkt[0].key = w_key_in;
        case (r_state)
            S_IDLE: begin
                if (start && !r_busy) begin
                    if (i_in.action == ACT_UPDATE) begin
                        n_done   = 1'b1;
                        n_result = '0;
                        if (w_sel_x >= w_cnt_x) begin
                            n_result.status = ST_BAD;
                        end else begin
                            w_wr.flag_en    = 1'b1;
                            w_wr.flag       = i_in.new_value;
                            w_wr_slot       = w_sel_x[IW-1:0];
                            n_result.status = ST_HIT;
                        end
                    end else begin
                        w_pkt[0].valid = 1'b1;
                        n_state        = S_SCAN;
                        n_busy         = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (w_pkt[CAPACITY].valid) begin
                    n_state  = S_IDLE;
                    n_busy   = 1'b0;
                    n_done   = 1'b1;
                    n_result = '0;
                    if (w_pkt[CAPACITY].found) begin
                        n_result.slot_index   = w_hit_x[SLOT_OUT_W-1:0];
                        n_result.stored_value = w_pkt[CAPACITY].flag;
                        n_result.status       = ST_HIT;
                    end else if (r_count == CW'(CAPACITY)) begin
                        n_result.status = ST_FULL;
                    end else begin
                        w_wr.key_en         = 1'b1;
                        w_wr.key            = w_pkt[CAPACITY].key;
                        w_wr.flag           = 1'b0;
                        w_wr_slot           = r_count[IW-1:0];
                        n_count             = r_count + CW'(1);
                        n_result.slot_index = w_new_x[SLOT_OUT_W-1:0];
                        n_result.status     = ST_NEW;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_count <= n_count;
        end
        r_result <= n_result;
    end

    assign busy     = r_busy;
    assign o_done   = r_done;
    assign o_result = r_result;

    // terms for the checks
    assign w_lookup_acc = start && !busy && (i_in.action == ACT_LOOKUP);
    assign w_new_done   = o_done && (o_result.status == ST_NEW);

    // checks
    `KFR_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `KFR_ASSERT_SAME(a_pkt_in_scan, i_clk, i_rst_n, w_pkt[CAPACITY].valid, r_state == S_SCAN)
    `KFR_ASSERT_NEXT(a_lookup_busy, i_clk, i_rst_n, w_lookup_acc, busy)
    `KFR_ASSERT_SAME(a_new_counts, i_clk, i_rst_n, w_new_done, r_count == $past(r_count) + CW'(1))

endmodule

### bench/keyed_flag_registry_top_tb.sv
`timescale 1ns / 1ps

module keyed_flag_registry_top_tb;
    import kfr_pkg::*;

    localparam int CAPACITY    = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 600000;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  stim;
    logic      o_done;
    t_out_item result;

    // shadow copy of the registry contents
    logic [HASH_W-1:0] reg_hash [CAPACITY];
    logic [15:0]       reg_zone [CAPACITY];
    logic [15:0]       reg_link [CAPACITY];
    logic              reg_flag [CAPACITY];
    int                reg_count;

    t_out_item expected_results[$];
    int        error_count;
    int        cycle_count;
    int        idle_pct;

    keyed_flag_registry_top #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (stim),
        .o_done  (o_done),
        .o_result(result)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // registry behavior: lookup with allocate on miss, or flag update
    function automatic t_out_item registry_predict(t_in_item it);
        t_out_item         res;
        logic [15:0]       masked;
        logic [HASH_W-1:0] h;
        int                hit_idx;
        res     = '0;
        masked  = it.key_hash & HASH_MASK;
        h       = masked[HASH_W-1:0];
        hit_idx = -1;
        if (it.action == ACT_LOOKUP) begin
            for (int i = 0; i < reg_count; i++) begin
                if (hit_idx < 0 && reg_hash[i] == h && reg_zone[i] == it.key_zone
                        && reg_link[i] == it.key_link)
                    hit_idx = i;
            end
            if (hit_idx >= 0) begin
                res.slot_index   = hit_idx[SLOT_OUT_W-1:0];
                res.stored_value = reg_flag[hit_idx];
                res.status       = ST_HIT;
            end else if (reg_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                reg_hash[reg_count] = h;
                reg_zone[reg_count] = it.key_zone;
                reg_link[reg_count] = it.key_link;
                reg_flag[reg_count] = 1'b0;
                res.slot_index      = reg_count[SLOT_OUT_W-1:0];
                res.status          = ST_NEW;
                reg_count++;
            end
        end else begin
            if (it.slot_select >= reg_count) begin
                res.status = ST_BAD;
            end else begin
                reg_flag[it.slot_select] = it.new_value;
                res.status               = ST_HIT;
            end
        end
        return res;
    endfunction

    function automatic t_in_item make_item(logic act, logic [15:0] h, logic [15:0] z,
                                           logic [15:0] l, logic [SLOT_SEL_W-1:0] sel,
                                           logic val);
        t_in_item it;
        it.action      = act;
        it.key_hash    = h;
        it.key_zone    = z;
        it.key_link    = l;
        it.slot_select = sel;
        it.new_value   = val;
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // send one transaction, with an optional idle gap before it
    task automatic send_transaction(input t_in_item it);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < idle_pct)
            gap = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 80);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        stim  <= it;
        do @(posedge i_clk); while (busy);
        expected_results.push_back(registry_predict(it));
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with no transaction pending");
            end else begin
                want = expected_results.pop_front();
                if (result.slot_index !== want.slot_index)
                    report_mismatch($sformatf("slot_index %0d, expected %0d",
                                              result.slot_index, want.slot_index));
                if (result.stored_value !== want.stored_value)
                    report_mismatch($sformatf("stored_value %0b, expected %0b",
                                              result.stored_value, want.stored_value));
                if (result.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              result.status, want.status));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("keyed_flag_registry_top regression: fail");
            $finish;
        end
    end

    // key extremes, hash masking, flag updates and bad slots
    task automatic test_directed();
        send_transaction(make_item(ACT_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 7'd0, 1'b0));
        send_transaction(make_item(ACT_LOOKUP, 16'h8000, 16'h0000, 16'h0000, 7'h7f, 1'b1));
        send_transaction(make_item(ACT_UPDATE, 16'hffff, 16'hffff, 16'hffff, 7'd0, 1'b1));
        send_transaction(make_item(ACT_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 7'd0, 1'b0));
        send_transaction(make_item(ACT_LOOKUP, 16'hffff, 16'hffff, 16'hffff, 7'd0, 1'b0));
        send_transaction(make_item(ACT_LOOKUP, 16'h7fff, 16'hffff, 16'hffff, 7'd5, 1'b1));
        send_transaction(make_item(ACT_UPDATE, 16'h0000, 16'h0000, 16'h0000, 7'd1, 1'b1));
        send_transaction(make_item(ACT_UPDATE, 16'h0000, 16'h0000, 16'h0000, 7'd2, 1'b1));
        send_transaction(make_item(ACT_UPDATE, 16'h0000, 16'h0000, 16'h0000, 7'h7f, 1'b0));
        send_transaction(make_item(ACT_UPDATE, 16'h0000, 16'h0000, 16'h0000, 7'd64, 1'b1));
        send_transaction(make_item(ACT_LOOKUP, 16'hffff, 16'hffff, 16'hffff, 7'd0, 1'b0));
        send_transaction(make_item(ACT_LOOKUP, 16'h0000, 16'h0001, 16'h0000, 7'd0, 1'b0));
        send_transaction(make_item(ACT_LOOKUP, 16'h0000, 16'h0000, 16'h8000, 7'd0, 1'b0));
        send_transaction(make_item(ACT_UPDATE, 16'h1234, 16'h5678, 16'h9abc, 7'd0, 1'b0));
        send_transaction(make_item(ACT_LOOKUP, 16'h8000, 16'h0000, 16'h0000, 7'd0, 1'b0));
        send_transaction(make_item(ACT_UPDATE, 16'h0000, 16'h0000, 16'h0000, 7'd4, 1'b1));
    endtask

    // random mix of hits, near misses, fresh keys and updates
    task automatic test_random_traffic(input int count, input int fresh_pct);
        t_in_item it;
        int       idx;
        int       pick;
        int       b;
        for (int n = 0; n < count; n++) begin
            it = make_item($urandom_range(0, 99) < 30 ? ACT_UPDATE : ACT_LOOKUP,
                           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)),
                           1'($urandom_range(0, 1)));
            if (it.action == ACT_LOOKUP && reg_count > 0) begin
                pick = $urandom_range(0, 99);
                if (pick >= fresh_pct) begin
                    idx         = $urandom_range(0, reg_count - 1);
                    it.key_hash = {1'($urandom_range(0, 1)), reg_hash[idx]};
                    it.key_zone = reg_zone[idx];
                    it.key_link = reg_link[idx];
                    // near miss: one key bit off
                    if (pick < fresh_pct + 15) begin
                        b = $urandom_range(0, 46);
                        if (b < 15)
                            it.key_hash[b] = ~it.key_hash[b];
                        else if (b < 31)
                            it.key_zone[b - 15] = ~it.key_zone[b - 15];
                        else
                            it.key_link[b - 31] = ~it.key_link[b - 31];
                    end
                end
            end else if (it.action == ACT_UPDATE && reg_count > 0
                         && $urandom_range(0, 99) < 80) begin
                it.slot_select = 7'($urandom_range(0, reg_count - 1));
            end
            send_transaction(it);
        end
    endtask

    // fill every slot, then exercise the full table and the top slot
    task automatic test_fill_and_overflow();
        t_in_item last;
        while (reg_count < CAPACITY)
            send_transaction(make_item(ACT_LOOKUP, 16'($urandom_range(0, 65535)),
                                       16'($urandom_range(0, 65535)),
                                       16'($urandom_range(0, 65535)),
                                       7'($urandom_range(0, 127)), 1'($urandom_range(0, 1))));
        last = make_item(ACT_LOOKUP, {1'b1, reg_hash[CAPACITY-1]}, reg_zone[CAPACITY-1],
                         reg_link[CAPACITY-1], 7'd0, 1'b0);
        send_transaction(make_item(ACT_LOOKUP, 16'h0000, 16'h0000, 16'h0001, 7'd0, 1'b0));
        send_transaction(make_item(ACT_LOOKUP, 16'hffff, 16'hfffe, 16'hffff, 7'd0, 1'b0));
        send_transaction(last);
        send_transaction(make_item(ACT_UPDATE, 16'h0000, 16'h0000, 16'h0000,
                                   7'(CAPACITY - 1), 1'b1));
        send_transaction(last);
        send_transaction(make_item(ACT_UPDATE, 16'h0000, 16'h0000, 16'h0000,
                                   7'(CAPACITY), 1'b1));
        send_transaction(make_item(ACT_UPDATE, 16'h0000, 16'h0000, 16'h0000, 7'h7f, 1'b1));
        send_transaction(make_item(ACT_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 7'd0, 1'b0));
    endtask

    // test sequence
    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        stim        = '0;
        reg_count   = 0;
        error_count = 0;
        cycle_count = 0;
        idle_pct    = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_traffic(200, 10);
        idle_pct = 61;
        test_random_traffic(200, 35);
        idle_pct = 13;
        test_fill_and_overflow();
        idle_pct = 0;
        test_random_traffic(100, 35);
        idle_pct = 13;
        test_random_traffic(120, 35);

        @(negedge i_clk);
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (CAPACITY + 8) @(posedge i_clk);
        if (error_count == 0)
            $display("keyed_flag_registry_top regression: pass");
        else
            $display("keyed_flag_registry_top regression: fail");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/kfr_pkg.sv
design/kfr_cell.sv
design/keyed_flag_registry_top.sv
bench/keyed_flag_registry_top_tb.sv
